// ===== rtl/core/mur_pkg.sv =====
// ----------------------------------------------------------------------------
// mur_pkg
// Shared types, register indexes and reset values for the multiplexed
// ultrasonic ranger.
// ----------------------------------------------------------------------------
package mur_pkg;

   localparam int unsigned SENSOR_COUNT_DEF = 8;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_SETTLE  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRIGGER = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_MM  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_MM  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED   = 3'd5;

   localparam logic [13:0] DIST_MAX = 14'd16383;

   typedef struct packed {
      logic       action;
      logic [2:0] channel;
      logic       echo_level;
   } req_type;

   typedef struct packed {
      logic        trigger_level;
      logic [2:0]  select_lines;
      logic        busy_res;
      logic        done_res;
      logic [13:0] distance_mm;
      logic        in_range;
      logic        timed_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0] settle_us;
      logic [7:0]  trigger_us;
      logic [15:0] timeout_us;
      logic [13:0] min_mm;
      logic [13:0] max_mm;
      logic [15:0] speed_factor_q16;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      settle_us:        16'd10000,
      trigger_us:       8'd10,
      timeout_us:       16'd23507,
      min_mm:           14'd20,
      max_mm:           14'd4000,
      speed_factor_q16: 16'd11151
   };

   // Outcome of one tick of the sequencer, before distance conversion.
   typedef struct packed {
      logic        trigger_level;
      logic [2:0]  select_lines;
      logic        busy_res;
      logic        done_res;
      logic        timed_out;
      logic        range_check;
      logic [15:0] dist_count;
   } step_type;

endpackage

// ===== rtl/core/mur_fsm.sv =====
// ----------------------------------------------------------------------------
// mur_fsm
// Measurement sequencer: select, settle, trigger pulse, echo rise wait and
// echo width count. Advances one tick per accepted request.
// ----------------------------------------------------------------------------
module mur_fsm #(
   parameter int unsigned SENSOR_COUNT = mur_pkg::SENSOR_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_go,
   input  mur_pkg::req_type  item,
   input  mur_pkg::cfg_type  cfg,
   output mur_pkg::step_type step
);
   import mur_pkg::*;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_SETTLE    = 3'd1;
   localparam logic [2:0] PH_TRIGGER   = 3'd2;
   localparam logic [2:0] PH_WAIT_RISE = 3'd3;
   localparam logic [2:0] PH_COUNT     = 3'd4;

   localparam logic [3:0] CHAN_LIMIT = 4'(SENSOR_COUNT);
   localparam logic [2:0] CHAN_TOP   = 3'(SENSOR_COUNT - 1);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [2:0]  sel_ff, sel_in;
   logic [16:0] inc;
   logic        done;
   logic        tout;
   logic        check;
   logic [15:0] dist_cnt;

   assign inc = {1'b0, cnt_ff} + 17'd1;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      done     = 1'b0;
      tout     = 1'b0;
      check    = 1'b0;
      dist_cnt = 16'd0;
      unique case (phase_ff)
         PH_SETTLE: begin
            if (inc >= {1'b0, cfg.settle_us}) begin
               phase_in = PH_TRIGGER;
               cnt_in   = 16'd0;
            end else begin
               cnt_in = inc[15:0];
            end
         end
         PH_TRIGGER: begin
            if (inc >= {9'd0, cfg.trigger_us}) begin
               phase_in = PH_WAIT_RISE;
               cnt_in   = 16'd0;
            end else begin
               cnt_in = inc[15:0];
            end
         end
         PH_WAIT_RISE: begin
            if (item.echo_level) begin
               if (cfg.timeout_us <= 16'd1) begin
                  done     = 1'b1;
                  tout     = 1'b1;
                  dist_cnt = cfg.timeout_us;
               end else begin
                  phase_in = PH_COUNT;
                  cnt_in   = 16'd1;
               end
            end else if (inc >= {1'b0, cfg.timeout_us}) begin
               done = 1'b1;
               tout = 1'b1;
            end else begin
               cnt_in = inc[15:0];
            end
         end
         PH_COUNT: begin
            if (item.echo_level) begin
               if (inc >= {1'b0, cfg.timeout_us}) begin
                  done     = 1'b1;
                  tout     = 1'b1;
                  dist_cnt = cfg.timeout_us;
               end else begin
                  cnt_in = inc[15:0];
               end
            end else begin
               done     = 1'b1;
               check    = 1'b1;
               dist_cnt = cnt_ff;
            end
         end
         default: begin
            if (item.action) begin
               sel_in   = ({1'b0, item.channel} >= CHAN_LIMIT) ? CHAN_TOP : item.channel;
               phase_in = PH_SETTLE;
               cnt_in   = 16'd0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
      if (done) begin
         phase_in = PH_IDLE;
         cnt_in   = 16'd0;
      end
   end

   always_comb begin
      step.trigger_level = (phase_in == PH_TRIGGER);
      step.select_lines  = sel_in;
      step.busy_res      = (phase_in != PH_IDLE);
      step.done_res      = done;
      step.timed_out     = tout;
      step.range_check   = check;
      step.dist_count    = dist_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= 16'd0;
         sel_ff   <= 3'd0;
      end else if (step_go) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// ===== rtl/core/muxed_ultrasonic_ranger.sv =====
// ----------------------------------------------------------------------------
// muxed_ultrasonic_ranger
// Echo ranging controller for up to eight multiplexed ultrasonic sensors, one tick
// per request, with Q0.16 conversion of echo width to millimetres.
// ----------------------------------------------------------------------------
// Path: a request passes the input register, the sequencer register, the 16x16
//   product register and the output register before it leaves as a response.
// Throughput: one request per cycle while nothing stalls; rsp_stall holds it off.
// Reset: config registers load their default values, sequencer idle, pipeline empty.
// ----------------------------------------------------------------------------
module muxed_ultrasonic_ranger #(
   parameter int unsigned SENSOR_COUNT = mur_pkg::SENSOR_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mur_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mur_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [mur_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [mur_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mur_pkg::*;

   cfg_type     cfg_ff, cfg_in;

   logic        in_vld_ff;
   req_type     in_data_ff;
   logic        mid_vld_ff;
   step_type    mid_step_ff;
   logic        prod_vld_ff;
   step_type    prod_step_ff;
   logic [31:0] prod_ff;
   logic        out_vld_ff;
   rsp_type     out_data_ff;

   logic        in_rdy;
   logic        mid_rdy;
   logic        prod_rdy;
   logic        out_rdy;
   logic        step_go;
   step_type    step;

   logic [32:0] rounded;
   logic [16:0] mm_wide;
   logic [13:0] mm_sat;
   rsp_type     out_data_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SETTLE:  cfg_in.settle_us        = csr_wdata;
            CSR_TRIGGER: cfg_in.trigger_us       = csr_wdata[7:0];
            CSR_TIMEOUT: cfg_in.timeout_us       = csr_wdata;
            CSR_MIN_MM:  cfg_in.min_mm           = csr_wdata[13:0];
            CSR_MAX_MM:  cfg_in.max_mm           = csr_wdata[13:0];
            CSR_SPEED:   cfg_in.speed_factor_q16 = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign out_rdy  = !out_vld_ff || !rsp_stall;
   assign prod_rdy = !prod_vld_ff || out_rdy;
   assign mid_rdy  = !mid_vld_ff || prod_rdy;
   assign in_rdy   = !in_vld_ff || mid_rdy;
   assign step_go  = in_vld_ff && mid_rdy;

   assign req_stall = !in_rdy;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   mur_fsm #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_go (step_go),
      .item    (in_data_ff),
      .cfg     (cfg_ff),
      .step    (step)
   );

   always_comb begin
      rounded = {1'b0, prod_ff} + 33'd32768;
      mm_wide = rounded[32:16];
      mm_sat  = (mm_wide > {3'd0, DIST_MAX}) ? DIST_MAX : mm_wide[13:0];
      out_data_in.trigger_level = prod_step_ff.trigger_level;
      out_data_in.select_lines  = prod_step_ff.select_lines;
      out_data_in.busy_res      = prod_step_ff.busy_res;
      out_data_in.done_res      = prod_step_ff.done_res;
      out_data_in.distance_mm   = mm_sat;
      out_data_in.in_range      = prod_step_ff.range_check
                                  && (mm_sat > cfg_ff.min_mm)
                                  && (mm_sat < cfg_ff.max_mm);
      out_data_in.timed_out     = prod_step_ff.timed_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         mid_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (in_rdy) begin
            in_vld_ff <= req_valid;
         end
         if (mid_rdy) begin
            mid_vld_ff <= in_vld_ff;
         end
         if (prod_rdy) begin
            prod_vld_ff <= mid_vld_ff;
         end
         if (out_rdy) begin
            out_vld_ff <= prod_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_rdy) begin
         in_data_ff <= req_data;
      end
      if (step_go) begin
         mid_step_ff <= step;
      end
      if (mid_vld_ff && prod_rdy) begin
         prod_step_ff <= mid_step_ff;
         prod_ff      <= {16'd0, mid_step_ff.dist_count}
                         * {16'd0, cfg_ff.speed_factor_q16};
      end
      if (prod_vld_ff && out_rdy) begin
         out_data_ff <= out_data_in;
      end
   end

   a_range_needs_clean_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_range |-> rsp_data.done_res && !rsp_data.timed_out
                                         && rsp_data.distance_mm > cfg_ff.min_mm)
      else $error("in_range without a clean finished measurement");

   a_trigger_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trigger_level |-> rsp_data.busy_res && !rsp_data.done_res)
      else $error("trigger driven outside a running measurement");

   a_distance_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.distance_mm == 14'd0
                                          && !rsp_data.timed_out)
      else $error("distance or timeout reported without done");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      step_go && step.done_res |-> !step.busy_res)
      else $error("sequencer still busy on the finishing tick");

endmodule
